FILE: hw/rtl/dsu_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dsu_pkg
// Shared types and constants of the disjoint-set union/find unit.
// ----------------------------------------------------------------------------
package dsu_pkg;

    localparam int NODE_W = 10;
    localparam int CNT_W  = 11;

    localparam logic [CNT_W-1:0] NODE_COUNT_RST = 11'd1024;

    typedef struct packed {
        logic              req_type;
        logic [NODE_W-1:0] node_a;
        logic [NODE_W-1:0] node_b;
    } t_in_item;

    typedef struct packed {
        logic              same_set;
        logic [NODE_W-1:0] root_a;
        logic [NODE_W-1:0] root_b;
        logic              bad_index;
    } t_out_item;

    localparam logic REQ_JOIN = 1'b0;
    localparam logic REQ_TEST = 1'b1;

    // Datapath commands issued by the controller
    typedef enum logic [3:0] {
        CMD_NONE,
        CMD_CLEAR,
        CMD_LOAD,
        CMD_RD_CUR,
        CMD_UP,
        CMD_ROOT,
        CMD_NEXT_B,
        CMD_RD_NODE,
        CMD_COMPRESS,
        CMD_RD_RA,
        CMD_RD_RB,
        CMD_LINK,
        CMD_GROW,
        CMD_EMIT
    } t_cmd;

    typedef struct packed {
        logic clr_done;
        logic in_bad;
        logic rd_root;
        logic node_at_root;
        logic sel_b;
        logic join_needed;
        logic out_free;
    } t_status;

endpackage

FILE: hw/rtl/dsu_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dsu_ctrl
// Sequencer: clearing pass, two finds with path compression (skipped for a
// rejected index), optional link, then hand-off to the output register.
// ----------------------------------------------------------------------------
module dsu_ctrl
    import dsu_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    input  t_status i_status,
    output t_cmd    o_cmd,
    output logic    o_in_stall
);

    typedef enum logic [10:0] {
        S_CLEAR  = 11'b000_0000_0001,
        S_IDLE   = 11'b000_0000_0010,
        S_F1_RD  = 11'b000_0000_0100,
        S_F1_CHK = 11'b000_0000_1000,
        S_F2_RD  = 11'b000_0001_0000,
        S_F2_WR  = 11'b000_0010_0000,
        S_JOIN   = 11'b000_0100_0000,
        S_J_RDB  = 11'b000_1000_0000,
        S_J_LINK = 11'b001_0000_0000,
        S_J_GROW = 11'b010_0000_0000,
        S_OUT    = 11'b100_0000_0000
    } t_state;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_stall = (r_state != S_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = CMD_NONE;
        case (r_state)
            S_CLEAR: begin
                o_cmd = CMD_CLEAR;
                if (i_status.clr_done) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd   = CMD_LOAD;
                    n_state = i_status.in_bad ? S_OUT : S_F1_RD;
                end
            end
            S_F1_RD: begin
                o_cmd   = CMD_RD_CUR;
                n_state = S_F1_CHK;
            end
            S_F1_CHK: begin
                if (i_status.rd_root) begin
                    o_cmd   = CMD_ROOT;
                    n_state = S_F2_RD;
                end else begin
                    o_cmd   = CMD_UP;
                    n_state = S_F1_RD;
                end
            end
            S_F2_RD: begin
                if (i_status.node_at_root) begin
                    if (i_status.sel_b) begin
                        n_state = S_JOIN;
                    end else begin
                        o_cmd   = CMD_NEXT_B;
                        n_state = S_F1_RD;
                    end
                end else begin
                    o_cmd   = CMD_RD_NODE;
                    n_state = S_F2_WR;
                end
            end
            S_F2_WR: begin
                o_cmd   = CMD_COMPRESS;
                n_state = S_F2_RD;
            end
            S_JOIN: begin
                if (i_status.join_needed) begin
                    o_cmd   = CMD_RD_RA;
                    n_state = S_J_RDB;
                end else begin
                    n_state = S_OUT;
                end
            end
            S_J_RDB: begin
                o_cmd   = CMD_RD_RB;
                n_state = S_J_LINK;
            end
            S_J_LINK: begin
                o_cmd   = CMD_LINK;
                n_state = S_J_GROW;
            end
            S_J_GROW: begin
                o_cmd   = CMD_GROW;
                n_state = S_OUT;
            end
            S_OUT: begin
                if (i_status.out_free) begin
                    o_cmd   = CMD_EMIT;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

endmodule

FILE: hw/rtl/dsu_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dsu_datapath
// Node record memory (root flag, parent, size), walk registers, config
// register and result register.
// ----------------------------------------------------------------------------
module dsu_datapath
    import dsu_pkg::*;
#(
    parameter int MAX_NODES = 1024
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_cmd             i_cmd,
    input  t_in_item         i_in_item,
    input  logic             i_out_stall,
    input  logic             i_cfg_valid,
    input  logic [CNT_W-1:0] i_cfg_data,
    output t_status          o_status,
    output logic             o_out_valid,
    output t_out_item        o_out_item
);

    localparam int IW = $clog2(MAX_NODES);
    localparam int SW = $clog2(MAX_NODES + 1);
    localparam int RW = 1 + IW + SW;

    // record layout: {root flag, parent, size}
    logic [RW-1:0] r_mem [MAX_NODES];
    logic [RW-1:0] r_rd;

    logic [CNT_W-1:0] r_node_count;
    logic [IW-1:0]    r_clr;
    logic             r_req, r_bad, r_sel;
    logic [IW-1:0]    r_b, r_start, r_cur, r_node, r_ra, r_rb, r_win;
    logic [SW-1:0]    r_size_a, r_sum;
    logic             r_ov;
    t_out_item        r_out;

    logic          rd_flag;
    logic [IW-1:0] rd_parent;
    logic [SW-1:0] rd_size;
    logic          in_bad, a_small;

    logic          we, re;
    logic [IW-1:0] waddr, raddr;
    logic [RW-1:0] wdata;

    assign rd_flag   = r_rd[RW-1];
    assign rd_parent = r_rd[SW +: IW];
    assign rd_size   = r_rd[SW-1:0];
    assign a_small   = (r_size_a < rd_size);

    // reject against both the configured count and the table depth
    assign in_bad = ({1'b0, i_in_item.node_a} >= r_node_count)
                 || ({1'b0, i_in_item.node_b} >= r_node_count)
                 || (32'(i_in_item.node_a) >= MAX_NODES)
                 || (32'(i_in_item.node_b) >= MAX_NODES);

    assign o_status.clr_done     = (r_clr == IW'(MAX_NODES - 1));
    assign o_status.in_bad       = in_bad;
    assign o_status.rd_root      = rd_flag;
    assign o_status.node_at_root = (r_node == r_cur);
    assign o_status.sel_b        = r_sel;
    assign o_status.join_needed  = (r_req == REQ_JOIN) && (r_ra != r_rb);
    assign o_status.out_free     = !r_ov || !i_out_stall;

    assign o_out_valid = r_ov;
    assign o_out_item  = r_out;

    always_comb begin
        we    = 1'b0;
        re    = 1'b0;
        waddr = r_clr;
        raddr = r_cur;
        wdata = {1'b1, {IW{1'b0}}, SW'(1)};
        case (i_cmd)
            CMD_CLEAR: begin
                we = 1'b1;
            end
            CMD_RD_CUR: begin
                re = 1'b1;
            end
            CMD_RD_NODE: begin
                re    = 1'b1;
                raddr = r_node;
            end
            CMD_COMPRESS: begin
                // a root reached mid-path ends the walk without a write
                we    = !rd_flag;
                waddr = r_node;
                wdata = {1'b0, r_cur, rd_size};
            end
            CMD_RD_RA: begin
                re    = 1'b1;
                raddr = r_ra;
            end
            CMD_RD_RB: begin
                re    = 1'b1;
                raddr = r_rb;
            end
            CMD_LINK: begin
                we = 1'b1;
                if (a_small) begin
                    waddr = r_ra;
                    wdata = {1'b0, r_rb, r_size_a};
                end else begin
                    waddr = r_rb;
                    wdata = {1'b0, r_ra, rd_size};
                end
            end
            CMD_GROW: begin
                we    = 1'b1;
                waddr = r_win;
                wdata = {1'b1, r_win, r_sum};
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (we) r_mem[waddr] <= wdata;
        if (re) r_rd <= r_mem[raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_node_count <= NODE_COUNT_RST;
            r_clr        <= '0;
            r_ov         <= 1'b0;
        end else begin
            if (i_cfg_valid) r_node_count <= i_cfg_data;
            if (i_cmd == CMD_CLEAR) r_clr <= r_clr + 1'b1;
            if (i_cmd == CMD_EMIT) begin
                r_ov <= 1'b1;
            end else if (!i_out_stall) begin
                r_ov <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        case (i_cmd)
            CMD_LOAD: begin
                r_req   <= i_in_item.req_type;
                r_bad   <= in_bad;
                r_b     <= IW'(i_in_item.node_b);
                r_start <= IW'(i_in_item.node_a);
                r_cur   <= IW'(i_in_item.node_a);
                r_sel   <= 1'b0;
            end
            CMD_UP: begin
                r_cur <= rd_parent;
            end
            CMD_ROOT: begin
                if (r_sel) begin
                    r_rb <= r_cur;
                end else begin
                    r_ra <= r_cur;
                end
                r_node <= r_start;
            end
            CMD_NEXT_B: begin
                r_start <= r_b;
                r_cur   <= r_b;
                r_sel   <= 1'b1;
            end
            CMD_COMPRESS: begin
                r_node <= rd_flag ? r_cur : rd_parent;
            end
            CMD_RD_RB: begin
                r_size_a <= rd_size;
            end
            CMD_LINK: begin
                r_win <= a_small ? r_rb : r_ra;
                r_sum <= r_size_a + rd_size;
            end
            CMD_EMIT: begin
                if (r_bad) begin
                    r_out <= '{same_set: 1'b0, root_a: '0, root_b: '0, bad_index: 1'b1};
                end else begin
                    r_out <= '{same_set: (r_ra == r_rb), root_a: NODE_W'(r_ra),
                               root_b: NODE_W'(r_rb), bad_index: 1'b0};
                end
            end
            default: begin
            end
        endcase
    end

    // linking only ever joins two distinct roots
    a_link_distinct: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd == CMD_LINK) |-> (r_ra != r_rb))
        else $error("link issued for equal roots");

    // compression never rewrites the root itself
    a_compress_not_root: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd == CMD_COMPRESS && !rd_flag) |-> (r_node != r_cur))
        else $error("compression targets the root");

    // a merged set cannot outgrow the table
    a_size_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd == CMD_GROW) |-> (32'(r_sum) <= MAX_NODES))
        else $error("set size exceeds node table");

    // rejected items report zero roots
    a_bad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd == CMD_EMIT && r_bad) |=>
            (o_out_item.root_a == '0 && o_out_item.root_b == '0 && !o_out_item.same_set))
        else $error("rejected item carries roots");

endmodule

FILE: hw/rtl/disjoint_set_union_find_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// disjoint_set_union_find_unit
// Union/find table with path compression and union by size.
// ----------------------------------------------------------------------------
// Input channel (i_in_valid / o_in_stall) carries one request item: join or
// test, and two node indices. Output channel (o_out_valid / i_out_stall)
// returns one result item per request: both roots, same-set flag and a
// bad-index flag. The config channel (i_cfg_valid / o_cfg_ready, always
// ready) writes node_count; write it only while the unit is idle.
// After reset a clearing pass writes every node record as a singleton root;
// requests are stalled meanwhile. Requests are handled one at a time on a
// single-port record memory with registered read; a rejected index goes
// straight to the output register. Every chain step is a memory read and
// its check, each compressed node a read and a write.
// The result waits in the output register while the receiver stalls; the
// next item is accepted meanwhile and its result is held back until the
// register frees.
// ----------------------------------------------------------------------------
module disjoint_set_union_find_unit
    import dsu_pkg::*;
#(
    parameter int MAX_NODES = 1024
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    input  t_in_item         i_in_item,
    output logic             o_out_valid,
    input  logic             i_out_stall,
    output t_out_item        o_out_item,
    input  logic             i_cfg_valid,
    output logic             o_cfg_ready,
    input  logic [CNT_W-1:0] i_cfg_data
);

    t_cmd    cmd;
    t_status status;

    assign o_cfg_ready = 1'b1;

    dsu_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_status   (status),
        .o_cmd      (cmd),
        .o_in_stall (o_in_stall)
    );

    dsu_datapath #(
        .MAX_NODES (MAX_NODES)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_in_item   (i_in_item),
        .i_out_stall (i_out_stall),
        .i_cfg_valid (i_cfg_valid && o_cfg_ready),
        .i_cfg_data  (i_cfg_data),
        .o_status    (status),
        .o_out_valid (o_out_valid),
        .o_out_item  (o_out_item)
    );

endmodule
